// ===== rtl/lsrc_pkg.sv =====
`default_nettype none
package lsrc_pkg;

  localparam int CoordW = 32;
  localparam int OffW   = 31;
  localparam int WideW  = 34;
  localparam int MagW   = 33;
  localparam int QuotW  = 33;
  localparam int ProdW  = 66;

  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_MAX_X    = 2'd2,
    REG_MAX_Y    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [WideW-1:0] a0;
    logic signed [WideW-1:0] b0;
    logic signed [WideW-1:0] a1;
    logic signed [WideW-1:0] b1;
  } seg_t;

  typedef struct packed {
    logic             ok;
    seg_t             seg;
  } item_t;

  typedef struct packed {
    logic                    fix0;
    logic                    fix1;
    logic signed [WideW-1:0] t0;
    logic signed [WideW-1:0] t1;
    logic                    neg0;
    logic                    neg1;
    logic [MagW-1:0]         mdb;
    logic [MagW-1:0]         mda;
    logic [MagW-1:0]         moff0;
    logic [MagW-1:0]         moff1;
  } clip_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/lsrc_divstage.sv =====
`default_nettype none
module lsrc_divstage #(
  parameter int NumW = 66,
  parameter int DenW = 33,
  parameter int Bits = 4
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [DenW:0]   rem_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den,
  output logic      [DenW:0]   rem_o,
  output logic      [NumW-1:0] num_o
);
  logic [DenW:0]   rem_nxt;
  logic [NumW-1:0] num_nxt;
  logic [DenW:0]   rem_r;
  logic [NumW-1:0] num_r;
  logic [DenW+1:0] trial;

  always_comb begin
    rem_nxt = rem_i;
    num_nxt = num_i;
    trial   = '0;
    for (int i = 0; i < Bits; i++) begin
      trial   = {rem_nxt, num_nxt[NumW-1]};
      num_nxt = {num_nxt[NumW-2:0], 1'b0};
      if (trial >= {2'b00, den}) begin
        trial      = trial - {2'b00, den};
        num_nxt[0] = 1'b1;
      end
      rem_nxt = trial[DenW:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign rem_o = rem_r;
  assign num_o = num_r;
endmodule
`default_nettype wire

// ===== rtl/lsrc_axis_clip.sv =====
`default_nettype none
module lsrc_axis_clip (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          vld_i,
  input  wire lsrc_pkg::item_t               item_i,
  input  wire logic [lsrc_pkg::OffW-1:0]     lim,
  output logic                               vld_o,
  output lsrc_pkg::item_t                    item_o
);
  localparam int W     = lsrc_pkg::WideW;
  localparam int M     = lsrc_pkg::MagW;
  localparam int P     = lsrc_pkg::ProdW;
  localparam int Bits  = 6;
  localparam int Steps = (P + Bits - 1) / Bits;

  logic signed [W-1:0] da, db, limw;
  logic lo0, hi0, lo1, hi1;
  lsrc_pkg::clip_ctl_t ctl_nxt, ctl_r;
  lsrc_pkg::item_t     c_item_r;
  logic                c_vld_r;

  function automatic logic [M-1:0] mag(input logic signed [W-1:0] v);
    logic signed [W-1:0] n;
    n = v[W-1] ? -v : v;
    return n[M-1:0];
  endfunction

  always_comb begin
    limw = $signed({{(W-lsrc_pkg::OffW){1'b0}}, lim});
    da  = item_i.seg.a1 - item_i.seg.a0;
    db  = item_i.seg.b1 - item_i.seg.b0;
    lo0 = item_i.seg.a0 < 0;
    hi0 = item_i.seg.a0 > limw;
    lo1 = item_i.seg.a1 < 0;
    hi1 = item_i.seg.a1 > limw;
    ctl_nxt.fix0  = lo0 | hi0;
    ctl_nxt.fix1  = lo1 | hi1;
    ctl_nxt.t0    = lo0 ? '0 : limw;
    ctl_nxt.t1    = lo1 ? '0 : limw;
    ctl_nxt.mdb   = mag(db);
    ctl_nxt.mda   = mag(da);
    ctl_nxt.moff0 = mag(ctl_nxt.t0 - item_i.seg.a0);
    ctl_nxt.moff1 = mag(ctl_nxt.t1 - item_i.seg.a1);
    ctl_nxt.neg0  = (db[W-1] ^ da[W-1]) ^ ((ctl_nxt.t0 - item_i.seg.a0) < 0);
    ctl_nxt.neg1  = (db[W-1] ^ da[W-1]) ^ ((ctl_nxt.t1 - item_i.seg.a1) < 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r        <= ctl_nxt;
      c_item_r.seg <= item_i.seg;
      c_item_r.ok  <= item_i.ok & ~((lo0 & lo1) | (hi0 & hi1));
    end
  end

  // products, registered
  logic [P-1:0] prod0_r, prod1_r;
  lsrc_pkg::clip_ctl_t pctl_r;
  lsrc_pkg::item_t     p_item_r;
  logic                p_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else if (en) begin
      p_vld_r <= c_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod0_r  <= ctl_r.mdb * ctl_r.moff0;
      prod1_r  <= ctl_r.mdb * ctl_r.moff1;
      pctl_r   <= ctl_r;
      p_item_r <= c_item_r;
    end
  end

  // divider pipeline, one per end
  logic [M:0]   rem0 [Steps+1];
  logic [M:0]   rem1 [Steps+1];
  logic [P-1:0] num0 [Steps+1];
  logic [P-1:0] num1 [Steps+1];
  lsrc_pkg::clip_ctl_t dctl [Steps+1];
  lsrc_pkg::item_t     ditem [Steps+1];
  logic                dvld [Steps+1];

  assign rem0[0]  = '0;
  assign rem1[0]  = '0;
  assign num0[0]  = prod0_r;
  assign num1[0]  = prod1_r;
  assign dctl[0]  = pctl_r;
  assign ditem[0] = p_item_r;
  assign dvld[0]  = p_vld_r;

  for (genvar s = 0; s < Steps; s++) begin : g_div
    lsrc_divstage #(.NumW(P), .DenW(M), .Bits(Bits)) u_d0 (
      .clk(clk), .en(en), .rem_i(rem0[s]), .num_i(num0[s]), .den(dctl[s].mda),
      .rem_o(rem0[s+1]), .num_o(num0[s+1]));
    lsrc_divstage #(.NumW(P), .DenW(M), .Bits(Bits)) u_d1 (
      .clk(clk), .en(en), .rem_i(rem1[s]), .num_i(num1[s]), .den(dctl[s].mda),
      .rem_o(rem1[s+1]), .num_o(num1[s+1]));
    lsrc_pkg::clip_ctl_t ctl_r2;
    lsrc_pkg::item_t     item_r2;
    logic                vld_r2;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r2 <= 1'b0;
      end else if (en) begin
        vld_r2 <= dvld[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r2  <= dctl[s];
        item_r2 <= ditem[s];
      end
    end
    assign dctl[s+1]  = ctl_r2;
    assign ditem[s+1] = item_r2;
    assign dvld[s+1]  = vld_r2;
  end

  // final adjust, remainders unused beyond the quotient
  logic signed [W-1:0] q0, q1;
  lsrc_pkg::item_t     o_nxt, o_r;
  logic                o_vld_r;
  lsrc_pkg::clip_ctl_t fc;

  always_comb begin
    fc = dctl[Steps];
    q0 = $signed({1'b0, num0[Steps][M-1:0]});
    q1 = $signed({1'b0, num1[Steps][M-1:0]});
    if (fc.neg0) q0 = -q0;
    if (fc.neg1) q1 = -q1;
    o_nxt = ditem[Steps];
    if (fc.fix0) begin
      o_nxt.seg.b0 = ditem[Steps].seg.b0 + q0;
      o_nxt.seg.a0 = fc.t0;
    end
    if (fc.fix1) begin
      o_nxt.seg.b1 = ditem[Steps].seg.b1 + q1;
      o_nxt.seg.a1 = fc.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= dvld[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_r <= o_nxt;
    end
  end

  assign vld_o  = o_vld_r;
  assign item_o = o_r;
endmodule
`default_nettype wire

// ===== rtl/lsrc_queue.sv =====
`default_nettype none
module lsrc_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr,
  input  wire logic [Width-1:0] wdata,
  input  wire logic             rd,
  output logic [Width-1:0]      rdata,
  output logic                  empty,
  output logic [$clog2(Depth+1)-1:0] count
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  logic [Width-1:0] mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [$clog2(Depth+1)-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  assign rdata = mem_r[rp_r];
  assign empty = (cnt_r == '0);
  assign count = cnt_r;
endmodule
`default_nettype wire

// ===== rtl/line_segment_rect_clip_core.sv =====
// one segment is accepted per cycle while in_full is low
// each axis pass holds two pipelined 66 by 33 bit dividers, 6 quotient bits per stage
// reset: rst_n is synchronous active low; queue empty, registers 0
`default_nettype none
module line_segment_rect_clip_core #(
  parameter int OutDepth = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic signed [31:0] in_start_x,
  input  wire logic signed [31:0] in_start_y,
  input  wire logic signed [31:0] in_end_x,
  input  wire logic signed [31:0] in_end_y,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_visible,
  output logic signed [31:0] out_clip_start_x,
  output logic signed [31:0] out_clip_start_y,
  output logic signed [31:0] out_clip_end_x,
  output logic signed [31:0] out_clip_end_y,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int W = lsrc_pkg::WideW;
  localparam int CW = $clog2(OutDepth+1);

  logic signed [31:0] org_x_r, org_y_r;
  logic [30:0] max_x_r, max_y_r;
  logic wr_en;
  lsrc_pkg::reg_idx_t widx;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;
  assign widx  = lsrc_pkg::reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0; max_x_r <= '0; max_y_r <= '0;
    end else if (wr_en) begin
      case (widx)
        lsrc_pkg::REG_ORIGIN_X: org_x_r <= cfg_pwdata;
        lsrc_pkg::REG_ORIGIN_Y: org_y_r <= cfg_pwdata;
        lsrc_pkg::REG_MAX_X:    max_x_r <= cfg_pwdata[30:0];
        lsrc_pkg::REG_MAX_Y:    max_y_r <= cfg_pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      lsrc_pkg::REG_ORIGIN_X: cfg_prdata = org_x_r;
      lsrc_pkg::REG_ORIGIN_Y: cfg_prdata = org_y_r;
      lsrc_pkg::REG_MAX_X:    cfg_prdata = {1'b0, max_x_r};
      lsrc_pkg::REG_MAX_Y:    cfg_prdata = {1'b0, max_y_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // front: credit count reserves a queue slot for every item in flight
  logic acc, pop_ok;
  logic [CW-1:0] inflight_r, qcount;
  lsrc_pkg::item_t in_item, x_item, y_in, y_item;
  logic x_vld, y_vld;
  assign acc    = in_push & ~in_full;
  assign pop_ok = out_pop & ~out_empty;
  assign in_full = ({1'b0, inflight_r} + {1'b0, qcount}) >= (CW+1)'(OutDepth);

  always_ff @(posedge clk) begin
    if (!rst_n) inflight_r <= '0;
    else inflight_r <= inflight_r + (acc ? 1'b1 : 1'b0) - (y_vld ? 1'b1 : 1'b0);
  end

  always_comb begin
    in_item.ok     = 1'b1;
    in_item.seg.a0 = W'(in_start_x) - W'(org_x_r);
    in_item.seg.b0 = W'(in_start_y) - W'(org_y_r);
    in_item.seg.a1 = W'(in_end_x) - W'(org_x_r);
    in_item.seg.b1 = W'(in_end_y) - W'(org_y_r);
  end

  lsrc_axis_clip u_x (
    .clk(clk), .rst_n(rst_n), .en(1'b1), .vld_i(acc), .item_i(in_item),
    .lim(max_x_r), .vld_o(x_vld), .item_o(x_item));

  always_comb begin
    y_in.ok     = x_item.ok;
    y_in.seg.a0 = x_item.seg.b0;
    y_in.seg.b0 = x_item.seg.a0;
    y_in.seg.a1 = x_item.seg.b1;
    y_in.seg.b1 = x_item.seg.a1;
  end

  lsrc_axis_clip u_y (
    .clk(clk), .rst_n(rst_n), .en(1'b1), .vld_i(x_vld), .item_i(y_in),
    .lim(max_y_r), .vld_o(y_vld), .item_o(y_item));

  // back: shift back, saturate, queue
  function automatic logic [31:0] sat(input logic signed [W-1:0] v);
    if (v > 34'sd2147483647) return 32'h7fffffff;
    if (v < -34'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  logic [128:0] res;
  always_comb begin
    res = '0;
    if (y_item.ok) begin
      res = {1'b1,
             sat(y_item.seg.b0 + W'(org_x_r)), sat(y_item.seg.a0 + W'(org_y_r)),
             sat(y_item.seg.b1 + W'(org_x_r)), sat(y_item.seg.a1 + W'(org_y_r))};
    end
  end

  logic [128:0] qdata;
  lsrc_queue #(.Width(129), .Depth(OutDepth)) u_q (
    .clk(clk), .rst_n(rst_n), .wr(y_vld), .wdata(res), .rd(pop_ok),
    .rdata(qdata), .empty(out_empty), .count(qcount));

  assign out_visible      = qdata[128];
  assign out_clip_start_x = qdata[127:96];
  assign out_clip_start_y = qdata[95:64];
  assign out_clip_end_x   = qdata[63:32];
  assign out_clip_end_y   = qdata[31:0];

  logic [CW-1:0] total;
  assign total = inflight_r + qcount;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    total <= CW'(OutDepth)) else $error("queue overrun");
  a_full_when_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    total == CW'(OutDepth) |-> in_full) else $error("accept past capacity");
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_visible |-> out_clip_start_x == '0 && out_clip_end_y == '0)
    else $error("rejected result not cleared");
endmodule
`default_nettype wire
